### rtl/core/mse_pkg.sv
// shared types, constants and control program for the merge sort engine
// no dependencies; used by every module of the block but mse_mem
package mse_pkg;

  // element width of the request and result structs
  localparam int unsigned DATA_W = 32;

  // one request: element to load, flag that closes the set
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } mse_req_t;

  // one result: next sorted element with its flags
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } mse_res_t;

  // datapath operations selected by the control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_BLK_RD,
    OP_HEAD,
    OP_MERGE,
    OP_BLK_END,
    OP_EMIT_RD,
    OP_EMIT
  } mse_op_e;

  // jump conditions
  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_LAST_ACC,
    CND_SORTED,
    CND_MERGE_DONE,
    CND_PASS_DONE,
    CND_EMIT_DONE
  } mse_cond_e;

  // program steps
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHK,
    ST_BLK_RD,
    ST_HEAD,
    ST_MERGE,
    ST_BLK_END,
    ST_EMIT_RD,
    ST_EMIT
  } mse_step_e;

  // one control word
  typedef struct packed {
    mse_op_e   op;
    logic      busy;
    mse_cond_e cond;
    mse_step_e jmp_t;
    mse_step_e jmp_f;
  } mse_uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic last_acc;
    logic sorted;
    logic merge_done;
    logic pass_done;
    logic emit_done;
  } mse_stat_t;

  // control program: load, bottom-up merge passes ping-ponging between two buffers, emit
  function automatic mse_uword_t mse_ucode(input mse_step_e step);
    mse_uword_t uw;
    unique case (step)
      ST_LOAD:    uw = '{OP_LOAD,    1'b0, CND_LAST_ACC,   ST_CHK,     ST_LOAD};
      ST_CHK:     uw = '{OP_NOP,     1'b1, CND_SORTED,     ST_EMIT_RD, ST_BLK_RD};
      ST_BLK_RD:  uw = '{OP_BLK_RD,  1'b1, CND_ALWAYS,     ST_HEAD,    ST_HEAD};
      ST_HEAD:    uw = '{OP_HEAD,    1'b1, CND_ALWAYS,     ST_MERGE,   ST_MERGE};
      ST_MERGE:   uw = '{OP_MERGE,   1'b1, CND_MERGE_DONE, ST_BLK_END, ST_MERGE};
      ST_BLK_END: uw = '{OP_BLK_END, 1'b1, CND_PASS_DONE,  ST_CHK,     ST_BLK_RD};
      ST_EMIT_RD: uw = '{OP_EMIT_RD, 1'b1, CND_ALWAYS,     ST_EMIT,    ST_EMIT};
      ST_EMIT:    uw = '{OP_EMIT,    1'b1, CND_EMIT_DONE,  ST_LOAD,    ST_EMIT};
      default:    uw = '{OP_NOP,     1'b0, CND_ALWAYS,     ST_LOAD,    ST_LOAD};
    endcase
    return uw;
  endfunction

endpackage

### rtl/core/mse_mem.sv
// element buffer: one write port, two registered read ports
// no package dependencies
module mse_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/core/mse_seq.sv
// microcode sequencer: step register, control store lookup, conditional jump
// depends on mse_pkg
module mse_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mse_pkg::mse_stat_t  stat_i,
  output mse_pkg::mse_uword_t uw_o
);
  import mse_pkg::*;

  mse_step_e  step_q, step_d;
  mse_uword_t uw;
  logic       hit;

  // step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  // control store and jump selection
  always_comb begin
    uw = mse_ucode(step_q);
    unique case (uw.cond)
      CND_ALWAYS:     hit = 1'b1;
      CND_LAST_ACC:   hit = stat_i.last_acc;
      CND_SORTED:     hit = stat_i.sorted;
      CND_MERGE_DONE: hit = stat_i.merge_done;
      CND_PASS_DONE:  hit = stat_i.pass_done;
      CND_EMIT_DONE:  hit = stat_i.emit_done;
      default:        hit = 1'b1;
    endcase
    step_d = hit ? uw.jmp_t : uw.jmp_f;
  end

  assign uw_o = uw;

endmodule

### rtl/core/mse_dp.sv
// datapath: two ping-pong buffers, merge head registers, block and pass pointers
// depends on mse_pkg and mse_mem
module mse_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mse_pkg::mse_req_t  req_i,
  input  mse_pkg::mse_op_e   op_i,
  output mse_pkg::mse_stat_t stat_o,
  output logic               res_valid_o,
  output mse_pkg::mse_res_t  res_o
);
  import mse_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WID_W = CNT_W + 1;
  localparam int unsigned SUM_W = CNT_W + 2;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             src_q, src_d;
  logic [WID_W-1:0] wid_q, wid_d;
  logic [CNT_W-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [DATA_W-1:0] ha_q, ha_d, hb_q, hb_d;

  logic [SUM_W-1:0] sum1, sum2;
  logic [CNT_W-1:0] mid_c, hi_c, k_inc;
  logic             a_ok, b_ok, take_a;

  logic             load_we, merge_we, we0, we1;
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b, rd_a, rd_b;

  // buffers; loading fills buffer 0, each pass writes the one not read
  mse_mem #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_mem0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  mse_mem #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_mem1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  assign rd_a = src_q ? rd1_a : rd0_a;
  assign rd_b = src_q ? rd1_b : rd0_b;

  // block bounds clipped to the set size
  assign sum1  = SUM_W'(lo_q) + SUM_W'(wid_q);
  assign sum2  = sum1 + SUM_W'(wid_q);
  assign mid_c = (sum1 < SUM_W'(cnt_q)) ? sum1[CNT_W-1:0] : cnt_q;
  assign hi_c  = (sum2 < SUM_W'(cnt_q)) ? sum2[CNT_W-1:0] : cnt_q;

  // stable merge choice: left head wins ties
  assign a_ok   = i_q < mid_q;
  assign b_ok   = j_q < hi_q;
  assign take_a = a_ok && (!b_ok || (ha_q <= hb_q));
  assign k_inc  = k_q + CNT_W'(1);

  // write port sharing between load and merge
  assign we0   = load_we || (merge_we && src_q);
  assign we1   = merge_we && !src_q;
  assign waddr = load_we ? cnt_q[IDX_W-1:0] : k_q[IDX_W-1:0];
  assign wdata = load_we ? req_i.value : (take_a ? ha_q : hb_q);

  // operation decode
  always_comb begin
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    src_d    = src_q;
    wid_d    = wid_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    hi_d     = hi_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    ha_d     = ha_q;
    hb_d     = hb_q;
    load_we  = 1'b0;
    merge_we = 1'b0;
    raddr_a  = i_q[IDX_W-1:0];
    raddr_b  = j_q[IDX_W-1:0];
    unique case (op_i)
      OP_LOAD: begin
        if (start_i) begin
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            load_we = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (req_i.last_item) begin
            wid_d = WID_W'(1);
            lo_d  = '0;
            src_d = 1'b0;
          end
        end
      end
      OP_BLK_RD: begin
        raddr_a = lo_q[IDX_W-1:0];
        raddr_b = mid_c[IDX_W-1:0];
        mid_d   = mid_c;
        hi_d    = hi_c;
        i_d     = lo_q;
        j_d     = mid_c;
        k_d     = lo_q;
      end
      OP_HEAD: begin
        ha_d    = rd_a;
        hb_d    = rd_b;
        raddr_a = IDX_W'(i_q + CNT_W'(1));
        raddr_b = IDX_W'(j_q + CNT_W'(1));
      end
      OP_MERGE: begin
        merge_we = 1'b1;
        k_d      = k_inc;
        if (take_a) begin
          i_d  = i_q + CNT_W'(1);
          ha_d = rd_a;
        end else begin
          j_d  = j_q + CNT_W'(1);
          hb_d = rd_b;
        end
        // prefetch the element after each new head
        raddr_a = IDX_W'(i_d + CNT_W'(1));
        raddr_b = IDX_W'(j_d + CNT_W'(1));
      end
      OP_BLK_END: begin
        lo_d = hi_q;
        if (hi_q == cnt_q) begin
          lo_d  = '0;
          wid_d = wid_q << 1;
          src_d = !src_q;
        end
      end
      OP_EMIT_RD: begin
        k_d     = '0;
        raddr_a = '0;
      end
      OP_EMIT: begin
        k_d     = k_inc;
        raddr_a = IDX_W'(k_inc);
        if (k_inc == cnt_q) begin
          cnt_d  = '0;
          drop_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      drop_q <= 1'b0;
      src_q  <= 1'b0;
      wid_q  <= WID_W'(1);
    end else begin
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
      src_q  <= src_d;
      wid_q  <= wid_d;
    end
  end

  // pointer and head registers
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    ha_q  <= ha_d;
    hb_q  <= hb_d;
  end

  // status for the sequencer
  assign stat_o.last_acc   = start_i && req_i.last_item;
  assign stat_o.sorted     = wid_q >= WID_W'(cnt_q);
  assign stat_o.merge_done = k_inc == hi_q;
  assign stat_o.pass_done  = hi_q == cnt_q;
  assign stat_o.emit_done  = k_inc == cnt_q;

  // result port
  assign res_valid_o         = op_i == OP_EMIT;
  assign res_o.sorted_value  = rd_a;
  assign res_o.last_out      = k_inc == cnt_q;
  assign res_o.overflow      = drop_q;

endmodule

### rtl/core/merge_sort_engine_unit.sv
// Loading takes one request per cycle while busy_o is low; after the last
// request the sort runs ceil(log2 n) passes over the n elements, then
// results follow, one per cycle, and cannot be stalled.
// A new set is taken from the cycle after the final result;
// reset clears count, overflow and sequencer.
// depends on mse_pkg, mse_seq, mse_dp
module merge_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mse_pkg::mse_req_t req_i,
  output logic              res_valid_o,
  output mse_pkg::mse_res_t res_o
);
  import mse_pkg::*;

  mse_uword_t uw;
  mse_stat_t  stat;

  // sequencer
  mse_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uw_o   (uw)
  );

  // datapath
  mse_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .op_i        (uw.op),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy_o = uw.busy;

endmodule

### rtl/core/mse_checker.sv
// port-level checks for merge_sort_engine_unit, attached by bind
// depends on mse_pkg and merge_sort_engine_unit
module mse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input mse_pkg::mse_req_t req_i,
  input logic              res_valid_i,
  input mse_pkg::mse_res_t res_i
);

  // results only while busy
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> busy_i)
    else $error("result outside busy window");

  // a request closing the set starts the sort
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && req_i.last_item) |=> busy_i)
    else $error("closing request did not start sort");

  // final result ends the burst and frees the block
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_i.last_out) |=> (!busy_i && !res_valid_i))
    else $error("block busy after final result");

  // overflow flag constant within a burst
  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && $past(res_valid_i)) |-> (res_i.overflow == $past(res_i.overflow)))
    else $error("overflow changed within a burst");

endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_i      (busy_o),
  .req_i       (req_i),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
